@@ rtl/tpq_pkg.sv @@
// Shared types and constants for the task priority queue.
// Used by tpq_ctrl, tpq_datapath and task_priority_queue_core; no dependencies.
package tpq_pkg;

    localparam int OP_W         = 2;
    localparam int ID_W         = 8;
    localparam int PRIO_PORT_W  = 8;
    localparam int COUNT_PORT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic step;
    } tpq_cmd_t;

endpackage

@@ rtl/tpq_ctrl.sv @@
// Handshake controller for the task priority queue.
// Depends on tpq_pkg; drives the step command into tpq_datapath.
module tpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              task_valid,
    output logic              task_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output tpq_pkg::tpq_cmd_t cmd
);

    tpq_pkg::ctrl_state_t state_reg;
    tpq_pkg::ctrl_state_t state_next;
    logic                 accept;

    // Take a new beat whenever the result slot is free or is being drained.
    assign task_ready   = (state_reg == tpq_pkg::ST_IDLE) || result_ready;
    assign result_valid = (state_reg == tpq_pkg::ST_HOLD);
    assign accept       = task_valid && task_ready;
    assign cmd.step     = accept;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpq_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = tpq_pkg::ST_HOLD;
            end
            tpq_pkg::ST_HOLD:
            begin
                if (accept)
                    state_next = tpq_pkg::ST_HOLD;
                else if (result_ready)
                    state_next = tpq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tpq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/tpq_datapath.sv @@
// Slot array, insert position search and result register of the task queue.
// Depends on tpq_pkg; stepped by tpq_ctrl through tpq_cmd_t.
module tpq_datapath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tpq_pkg::tpq_cmd_t                cmd,
    input  logic [tpq_pkg::OP_W-1:0]         operation,
    input  logic [tpq_pkg::ID_W-1:0]         task_id,
    input  logic [tpq_pkg::PRIO_PORT_W-1:0]  task_priority,
    output logic                             ok,
    output logic                             preempt,
    output logic                             head_valid,
    output logic [tpq_pkg::ID_W-1:0]         head_task_id,
    output logic [tpq_pkg::PRIO_PORT_W-1:0]  head_priority,
    output logic [tpq_pkg::COUNT_PORT_W-1:0] entry_count
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_CW = tpq_pkg::COUNT_PORT_W;
    localparam int PW     = PRIORITY_BITS;
    localparam int EW     = PRIORITY_BITS + tpq_pkg::PRIO_PORT_W;

    logic [tpq_pkg::ID_W-1:0] id_reg   [QUEUE_DEPTH];
    logic [tpq_pkg::ID_W-1:0] id_next  [QUEUE_DEPTH];
    logic [PW-1:0]            prio_reg [QUEUE_DEPTH];
    logic [PW-1:0]            prio_next[QUEUE_DEPTH];
    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;

    logic                            ok_reg;
    logic                            preempt_reg;
    logic                            head_valid_reg;
    logic [tpq_pkg::ID_W-1:0]        head_id_reg;
    logic [tpq_pkg::PRIO_PORT_W-1:0] head_prio_reg;
    logic [CNT_W-1:0]                count_reg;

    tpq_pkg::op_t  op;
    logic [EW-1:0] prio_in_ext;
    logic [PW-1:0] new_prio;
    logic          not_full;
    logic          not_empty;
    logic          do_add;
    logic          do_rem;
    logic          preempt_now;
    logic [CNT_W-1:0] scan_pos;
    logic [CNT_W-1:0] ins_pos;
    logic [EW-1:0]    head_prio_ext;

    assign op          = tpq_pkg::op_t'(operation);
    assign prio_in_ext = {{PW{1'b0}}, task_priority};
    assign new_prio    = prio_in_ext[PW-1:0];
    assign not_full    = (occ_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty   = (occ_reg != '0);
    assign do_add      = ((op == tpq_pkg::OP_APPEND) || (op == tpq_pkg::OP_INSERT)) && not_full;
    assign do_rem      = (op == tpq_pkg::OP_REMOVE) && not_empty;
    assign preempt_now = (op == tpq_pkg::OP_INSERT) && not_full && not_empty
                         && (prio_reg[0] < new_prio);

    // First slot after the head whose priority is at most the new one.
    always_comb
    begin
        scan_pos = occ_reg;
        for (int k = QUEUE_DEPTH - 1; k >= 1; k--)
        begin
            if ((CNT_W'(k) < occ_reg) && (prio_reg[k] <= new_prio))
                scan_pos = CNT_W'(k);
        end
    end

    always_comb
    begin
        priority if (op == tpq_pkg::OP_APPEND)
            ins_pos = occ_reg;
        else if (!not_empty || preempt_now)
            ins_pos = '0;
        else
            ins_pos = scan_pos;
    end

    // Each slot loads the new task, its lower neighbor, or its upper neighbor.
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_slot
        always_comb
        begin
            id_next[g]   = id_reg[g];
            prio_next[g] = prio_reg[g];
            if (do_add)
            begin
                if (CNT_W'(g) == ins_pos)
                begin
                    id_next[g]   = task_id;
                    prio_next[g] = new_prio;
                end
                if (g > 0)
                begin
                    if (CNT_W'(g) > ins_pos)
                    begin
                        id_next[g]   = id_reg[(g > 0) ? g - 1 : 0];
                        prio_next[g] = prio_reg[(g > 0) ? g - 1 : 0];
                    end
                end
            end
            else if (do_rem)
            begin
                if (g < QUEUE_DEPTH - 1)
                begin
                    id_next[g]   = id_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    prio_next[g] = prio_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_comb
    begin
        priority if (do_add)
            occ_next = occ_reg + CNT_W'(1);
        else if (do_rem)
            occ_next = occ_reg - CNT_W'(1);
        else
            occ_next = occ_reg;
    end

    assign head_prio_ext = {{tpq_pkg::PRIO_PORT_W{1'b0}}, prio_next[0]};

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            id_reg   <= id_next;
            prio_reg <= prio_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (cmd.step)
            occ_reg <= occ_next;
    end

    // Capture the post-step view of the queue for the result beat.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            ok_reg         <= do_add || do_rem;
            preempt_reg    <= preempt_now;
            head_valid_reg <= (occ_next != '0);
            head_id_reg    <= (occ_next != '0) ? id_next[0] : '0;
            head_prio_reg  <= (occ_next != '0) ? head_prio_ext[tpq_pkg::PRIO_PORT_W-1:0] : '0;
            count_reg      <= occ_next;
        end
    end

    assign ok            = ok_reg;
    assign preempt       = preempt_reg;
    assign head_valid    = head_valid_reg;
    assign head_task_id  = head_id_reg;
    assign head_priority = head_prio_reg;
    assign entry_count   = OUT_CW'(count_reg);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && do_add |=> occ_reg == $past(occ_reg) + CNT_W'(1))
        else $error("accepted add did not grow occupancy");

    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && (op == tpq_pkg::OP_REMOVE) && !not_empty |=> !ok_reg && (occ_reg == '0))
        else $error("remove on empty queue reported success");

    a_head_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (head_valid_reg == (count_reg != '0)) && (count_reg == occ_reg))
        else $error("result head flag disagrees with count");

endmodule

@@ rtl/task_priority_queue_core.sv @@
// Task priority queue: shift-register slots with a parallel insert search.
// Each accepted input beat has its result beat registered and shown in the next cycle.
// Throughput: one operation per cycle while results drain; the whole slot array shifts at once.
// A waiting result holds off the next input beat unless it drains in the same cycle.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending result.
// Depends on tpq_pkg, tpq_ctrl and tpq_datapath.
module task_priority_queue_core #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             task_valid,
    output logic                             task_ready,
    input  logic [tpq_pkg::OP_W-1:0]         operation,
    input  logic [tpq_pkg::ID_W-1:0]         task_id,
    input  logic [tpq_pkg::PRIO_PORT_W-1:0]  task_priority,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             ok,
    output logic                             preempt,
    output logic                             head_valid,
    output logic [tpq_pkg::ID_W-1:0]         head_task_id,
    output logic [tpq_pkg::PRIO_PORT_W-1:0]  head_priority,
    output logic [tpq_pkg::COUNT_PORT_W-1:0] entry_count
);

    tpq_pkg::tpq_cmd_t cmd;

    tpq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_ready   (task_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    tpq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (operation),
        .task_id       (task_id),
        .task_priority (task_priority),
        .ok            (ok),
        .preempt       (preempt),
        .head_valid    (head_valid),
        .head_task_id  (head_task_id),
        .head_priority (head_priority),
        .entry_count   (entry_count)
    );

endmodule
